@@ rtl/trid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package trid_pkg;

   localparam int DATA_W        = 32;
   localparam int PROD_W        = 64;
   localparam int IDX_W         = 6;
   localparam int FAULT_W       = 2;
   localparam int MAX_ROWS_DEF  = 64;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [FAULT_W-1:0] FAULT_NONE       = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_ZERO_PIVOT = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_TOO_MANY   = 2'd2;
   localparam logic [FAULT_W-1:0] FAULT_SATURATED  = 2'd3;

   // Clamps a 65-bit signed value to 32 bits. The top bit of the result is the
   // saturation flag, the lower 32 bits are the clamped value.
   function automatic logic [DATA_W:0] sat32(input logic [PROD_W:0] x);
      logic [DATA_W:0] r;
      if (x[PROD_W:DATA_W-1] == '0 || x[PROD_W:DATA_W-1] == '1) begin
         r = {1'b0, x[DATA_W-1:0]};
      end else if (x[PROD_W]) begin
         r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/trid_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Signed 64 by 32 bit division, truncating toward zero, one quotient bit per
// cycle. A zero divisor gives a zero quotient.
module trid_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [trid_pkg::PROD_W-1:0]  num,
   input  wire logic [trid_pkg::DATA_W-1:0]  den,
   output logic                              done,
   output logic [trid_pkg::PROD_W-1:0]       quot
);
   import trid_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);

   logic                  busy_ff, busy_in;
   logic                  fix_ff, fix_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PROD_W-1:0]     numr_ff, numr_in;
   logic [PROD_W-1:0]     quot_ff, quot_in;
   logic [DATA_W:0]       rem_ff, rem_in;
   logic [DATA_W-1:0]     den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic                  zero_ff, zero_in;
   logic [DATA_W:0]       shifted;
   logic [DATA_W+1:0]     trial;

   assign shifted = {rem_ff[DATA_W-1:0], numr_ff[PROD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      numr_in = numr_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         numr_in = num[PROD_W-1] ? (~num + 1'b1) : num;
         den_in  = den[DATA_W-1] ? (~den + 1'b1) : den;
         rem_in  = '0;
         quot_in = '0;
         neg_in  = num[PROD_W-1] ^ den[DATA_W-1];
         zero_in = (den == '0);
      end else if (busy_ff) begin
         numr_in = {numr_ff[PROD_W-2:0], 1'b0};
         if (!trial[DATA_W+1]) begin
            rem_in  = trial[DATA_W:0];
            quot_in = {quot_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         if (zero_ff) begin
            quot_in = '0;
         end else if (neg_ff) begin
            quot_in = ~quot_ff + 1'b1;
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      numr_ff <= numr_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

@@ rtl/tridiagonal_system_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Carries
// req_*     in         one matrix row: tdata = sub_diag[31:0], main_diag[63:32],
//                      super_diag[95:64], rhs[127:96]; tlast = last_row
// rsp_*     out        one solution: tdata = solution[31:0], row_index[37:32],
//                      zero pad; tlast = last_result; tuser = fault
//
// Each row after the first costs two multiply and divide passes through one
// shared radix-2 divider of 64 quotient bits in forward elimination; in back
// substitution the last row costs one pass and the remaining rows two each.
// Reset is synchronous and active high; it clears the row count, the fault
// flags and the sequencer. A stalled result only holds the sequencer at the
// point where the next solution is ready to leave.
module tridiagonal_system_solver #(
   parameter int MAX_ROWS  = trid_pkg::MAX_ROWS_DEF,
   parameter int FRAC_BITS = trid_pkg::FRAC_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // sub_diag, main_diag, super_diag, rhs from the lowest bit up
   input  wire logic [127:0] req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // solution, row_index, zero pad from the lowest bit up
   output logic [39:0]       rsp_tdata,
   // fault
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready
);
   import trid_pkg::*;

   localparam int AW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_ROWS + 1);
   localparam int ROW_W = 3 * DATA_W;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_READ   = 7'b0000010,
      S_MUL    = 7'b0000100,
      S_DSTART = 7'b0001000,
      S_DWAIT  = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   // One row per entry: pivot, modified right-hand side, super-diagonal.
   logic [ROW_W-1:0] mem [MAX_ROWS];
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;

   state_type              state_ff, state_in;
   logic [CW-1:0]          row_count_ff, row_count_in;
   logic [FAULT_W-1:0]     fault_ff, fault_in;
   logic                   back_ff, back_in;
   logic                   phase_ff, phase_in;
   logic [AW-1:0]          k_ff, k_in;
   logic [AW-1:0]          top_ff, top_in;
   logic                   pz_ff, pz_in;
   logic                   sat_ff, sat_in;
   logic                   last_ff, last_in;
   logic signed [DATA_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [DATA_W-1:0]      nb_ff, nb_in, nd_ff, nd_in, res_ff, res_in;
   logic [DATA_W-1:0]      next_ff, next_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [PROD_W-1:0]      q0_ff, q0_in;

   logic                   out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]      out_sol_ff, out_sol_in;
   logic [IDX_W-1:0]       out_idx_ff, out_idx_in;
   logic                   out_last_ff, out_last_in;
   logic [FAULT_W-1:0]     out_fault_ff, out_fault_in;

   logic                   div_done;
   logic [PROD_W-1:0]      div_quot;

   logic signed [DATA_W-1:0] piv, rhsp, upp;
   logic [CW-1:0]          rc_m1;
   logic [PROD_W:0]        lhs, rhs_term, diff;
   logic [DATA_W:0]        sat_res;
   logic [FAULT_W-1:0]     own_fault;
   logic                   req_fire, out_free;

   assign piv  = rd_data_ff[3*DATA_W-1:2*DATA_W];
   assign rhsp = rd_data_ff[2*DATA_W-1:DATA_W];
   assign upp  = rd_data_ff[DATA_W-1:0];

   assign rc_m1    = row_count_ff - 1'b1;
   assign rd_en    = (state_ff == S_READ);
   assign rd_addr  = back_ff ? k_ff : rc_m1[AW-1:0];
   assign wr_en    = (state_ff == S_WRITE);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[row_count_ff[AW-1:0]] <= {nb_ff, nd_ff, c_ff};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   trid_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DSTART),
      .num   (prod_ff),
      .den   (piv),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Operands of the subtraction that closes each division pass.
   always_comb begin
      if (!back_ff) begin
         lhs      = phase_ff ? {{(PROD_W-DATA_W+1){d_ff[DATA_W-1]}}, d_ff}
                             : {{(PROD_W-DATA_W+1){b_ff[DATA_W-1]}}, b_ff};
         rhs_term = {div_quot[PROD_W-1], div_quot};
      end else if (phase_ff) begin
         lhs      = {q0_ff[PROD_W-1], q0_ff};
         rhs_term = {div_quot[PROD_W-1], div_quot};
      end else begin
         lhs      = {div_quot[PROD_W-1], div_quot};
         rhs_term = '0;
      end
      diff    = lhs - rhs_term;
      sat_res = sat32(diff);
   end

   always_comb begin
      if (pz_ff) begin
         own_fault = FAULT_ZERO_PIVOT;
      end else if (sat_ff) begin
         own_fault = FAULT_SATURATED;
      end else begin
         own_fault = FAULT_NONE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_count_in = row_count_ff;
      fault_in     = fault_ff;
      back_in      = back_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      top_in       = top_ff;
      pz_in        = pz_ff;
      sat_in       = sat_ff;
      last_in      = last_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      nb_in        = nb_ff;
      nd_in        = nd_ff;
      res_in       = res_ff;
      next_in      = next_ff;
      prod_in      = prod_ff;
      q0_in        = q0_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_sol_in   = out_sol_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      out_fault_in = out_fault_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               a_in     = req_tdata[DATA_W-1:0];
               b_in     = req_tdata[2*DATA_W-1:DATA_W];
               c_in     = req_tdata[3*DATA_W-1:2*DATA_W];
               d_in     = req_tdata[4*DATA_W-1:3*DATA_W];
               last_in  = req_tlast;
               pz_in    = 1'b0;
               sat_in   = 1'b0;
               phase_in = 1'b0;
               back_in  = 1'b0;
               if (row_count_ff >= CW'(MAX_ROWS)) begin
                  // Row beyond capacity is dropped; a final flag still solves.
                  if (fault_ff == FAULT_NONE) begin
                     fault_in = FAULT_TOO_MANY;
                  end
                  if (req_tlast) begin
                     back_in  = 1'b1;
                     k_in     = AW'(MAX_ROWS - 1);
                     top_in   = AW'(MAX_ROWS - 1);
                     state_in = S_READ;
                  end
               end else if (row_count_ff == '0) begin
                  nb_in    = req_tdata[2*DATA_W-1:DATA_W];
                  nd_in    = req_tdata[4*DATA_W-1:3*DATA_W];
                  state_in = S_WRITE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (!phase_ff) begin
               pz_in = (piv == '0);
            end
            if (!back_ff) begin
               prod_in = phase_ff ? PROD_W'(a_ff * rhsp) : PROD_W'(a_ff * upp);
            end else if (!phase_ff) begin
               prod_in = {{(PROD_W-DATA_W){rhsp[DATA_W-1]}}, rhsp} << FRAC_BITS;
            end else begin
               prod_in = PROD_W'(upp * $signed(next_ff));
            end
            state_in = S_DSTART;
         end
         S_DSTART: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               if (!back_ff) begin
                  if (!phase_ff) begin
                     nb_in    = sat_res[DATA_W-1:0];
                     sat_in   = sat_res[DATA_W];
                     phase_in = 1'b1;
                     state_in = S_MUL;
                  end else begin
                     nd_in    = sat_res[DATA_W-1:0];
                     sat_in   = sat_ff | sat_res[DATA_W];
                     state_in = S_WRITE;
                  end
               end else if (!phase_ff && k_ff != top_ff) begin
                  q0_in    = div_quot;
                  phase_in = 1'b1;
                  state_in = S_MUL;
               end else begin
                  res_in   = sat_res[DATA_W-1:0];
                  sat_in   = sat_res[DATA_W];
                  state_in = S_EMIT;
               end
            end
         end
         S_WRITE: begin
            if (fault_ff == FAULT_NONE) begin
               if (pz_ff) begin
                  fault_in = FAULT_ZERO_PIVOT;
               end else if (sat_ff) begin
                  fault_in = FAULT_SATURATED;
               end
            end
            row_count_in = row_count_ff + 1'b1;
            if (last_ff) begin
               back_in  = 1'b1;
               phase_in = 1'b0;
               k_in     = row_count_ff[AW-1:0];
               top_in   = row_count_ff[AW-1:0];
               state_in = S_READ;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_sol_in   = res_ff;
               out_idx_in   = IDX_W'(k_ff);
               out_last_in  = (k_ff == '0);
               out_fault_in = (fault_ff != FAULT_NONE) ? fault_ff : own_fault;
               next_in      = res_ff;
               phase_in     = 1'b0;
               if (k_ff == '0) begin
                  row_count_in = '0;
                  fault_in     = FAULT_NONE;
                  back_in      = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  k_in     = k_ff - 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_count_ff <= '0;
         fault_ff     <= FAULT_NONE;
         back_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         fault_ff     <= fault_in;
         back_ff      <= back_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      k_ff         <= k_in;
      top_ff       <= top_in;
      pz_ff        <= pz_in;
      sat_ff       <= sat_in;
      last_ff      <= last_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      d_ff         <= d_in;
      nb_ff        <= nb_in;
      nd_ff        <= nd_in;
      res_ff       <= res_in;
      next_ff      <= next_in;
      prod_ff      <= prod_in;
      q0_ff        <= q0_in;
      out_sol_ff   <= out_sol_in;
      out_idx_ff   <= out_idx_in;
      out_last_ff  <= out_last_in;
      out_fault_ff <= out_fault_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_idx_ff, out_sol_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_fault_ff;

endmodule

`default_nettype wire
